/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by first_fit_heap_allocator
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ffa_pkg.sv */
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared constants and types of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;

    localparam int MAX_UNITS  = 64;
    localparam int UNIT_BYTES = 8;
    localparam int UNIT_SH    = $clog2(UNIT_BYTES);
    localparam int UNIT_W     = $clog2(MAX_UNITS);         // block index
    localparam int LEN_W      = $clog2(MAX_UNITS + 1);     // block length
    localparam int ENTRY_W    = LEN_W + 1;                 // {used, len}

    localparam int CFG_W      = 7;
    localparam int SIZE_W     = 10;
    localparam int ADDR_W     = 9;
    localparam int STATUS_W   = 2;
    localparam int WANT_W     = SIZE_W - UNIT_SH + 1;

    localparam logic [CFG_W-1:0] HEAP_UNITS_RESET = CFG_W'(40);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREE_FAIL = 2'd2;

    typedef struct packed {
        logic               we;
        logic [UNIT_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [UNIT_W-1:0]  raddr;
    } mem_req_t;

endpackage

/* design/ffa_ram.sv */
// ---------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/ffa_walk.sv */
// ---------------------------------------------------------------------------
// ffa_walk
// Block walker: read-modify-write sequencer over the block table.
// ---------------------------------------------------------------------------
module ffa_walk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            reinit,
    input  logic [ffa_pkg::LEN_W-1:0]       n_units,
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic [ffa_pkg::SIZE_W-1:0]      size_bytes,
    input  logic [ffa_pkg::ADDR_W-1:0]      free_addr,
    output logic                            done,
    output logic [ffa_pkg::STATUS_W-1:0]    status,
    output logic [ffa_pkg::ADDR_W-1:0]      addr,
    output ffa_pkg::mem_req_t               mem_req,
    input  logic [ffa_pkg::ENTRY_W-1:0]     rdata
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_SPLIT = 3'd3;
    localparam logic [2:0] ST_FNEXT = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [ffa_pkg::UNIT_W-1:0]       s_reg, s_next;
    logic                             op_reg, op_next;
    logic [ffa_pkg::WANT_W-1:0]       want_reg, want_next;
    logic [ffa_pkg::ADDR_W-1:0]       target_reg, target_next;
    logic [ffa_pkg::UNIT_W-1:0]       prev_s_reg, prev_s_next;
    logic [ffa_pkg::LEN_W-1:0]        prev_len_reg, prev_len_next;
    logic                             prev_free_reg, prev_free_next;
    logic [ffa_pkg::UNIT_W-1:0]       cur_s_reg, cur_s_next;
    logic [ffa_pkg::LEN_W-1:0]        cur_len_reg, cur_len_next;
    logic [ffa_pkg::UNIT_W-1:0]       split_s_reg, split_s_next;
    logic [ffa_pkg::LEN_W-1:0]        split_len_reg, split_len_next;
    logic                             done_reg, done_next;
    logic [ffa_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [ffa_pkg::ADDR_W-1:0]       addr_reg, addr_next;

    logic [ffa_pkg::LEN_W-1:0]        e_len;
    logic                             e_used;
    logic [ffa_pkg::LEN_W-1:0]        blk_end;
    logic                             at_end;
    logic [ffa_pkg::ADDR_W-1:0]       s_addr;
    logic [ffa_pkg::SIZE_W:0]         size_round;
    logic [ffa_pkg::WANT_W-1:0]       want_calc;
    logic [ffa_pkg::LEN_W-1:0]        free_len;
    logic [ffa_pkg::UNIT_W-1:0]       free_s;

    assign e_len   = rdata[ffa_pkg::LEN_W-1:0];
    assign e_used  = rdata[ffa_pkg::LEN_W];
    assign blk_end = ffa_pkg::LEN_W'(s_reg) + e_len;
    assign at_end  = (blk_end >= n_units);
    assign s_addr  = ffa_pkg::ADDR_W'(s_reg) << ffa_pkg::UNIT_SH;

    // round up to whole units, zero bytes counts as one unit
    assign size_round = (ffa_pkg::SIZE_W + 1)'(size_bytes)
                      + (ffa_pkg::SIZE_W + 1)'(ffa_pkg::UNIT_BYTES - 1);
    assign want_calc  = (size_round[ffa_pkg::SIZE_W:ffa_pkg::UNIT_SH] == '0)
                      ? ffa_pkg::WANT_W'(1)
                      : size_round[ffa_pkg::SIZE_W:ffa_pkg::UNIT_SH];

    // freed block plus a free follower, if one was read
    always_comb
    begin
        if (state_reg == ST_FNEXT)
        begin
            free_s   = cur_s_reg;
            free_len = e_used ? cur_len_reg : ffa_pkg::LEN_W'(cur_len_reg + e_len);
        end
        else
        begin
            free_s   = s_reg;
            free_len = e_len;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        op_next        = op_reg;
        want_next      = want_reg;
        target_next    = target_reg;
        prev_s_next    = prev_s_reg;
        prev_len_next  = prev_len_reg;
        prev_free_next = prev_free_reg;
        cur_s_next     = cur_s_reg;
        cur_len_next   = cur_len_reg;
        split_s_next   = split_s_reg;
        split_len_next = split_len_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        addr_next      = addr_reg;
        mem_req        = '0;
        mem_req.waddr  = s_reg;
        mem_req.raddr  = s_reg;

        case (state_reg)
            ST_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = {1'b0, n_units};
                state_next    = ST_IDLE;
            end
            ST_IDLE:
            begin
                mem_req.raddr = '0;
                if (start)
                begin
                    op_next        = op;
                    want_next      = want_calc;
                    target_next    = free_addr;
                    s_next         = '0;
                    prev_free_next = 1'b0;
                    state_next     = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (op_reg == ffa_pkg::OP_ALLOC)
                begin
                    if (!e_used && (ffa_pkg::WANT_W'(e_len) >= want_reg))
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = s_reg;
                        mem_req.wdata = {1'b1, ffa_pkg::LEN_W'(want_reg)};
                        status_next   = ffa_pkg::STATUS_OK;
                        addr_next     = s_addr;
                        if (ffa_pkg::WANT_W'(e_len) > want_reg)
                        begin
                            split_s_next   = ffa_pkg::UNIT_W'(ffa_pkg::WANT_W'(s_reg)
                                                              + want_reg);
                            split_len_next = ffa_pkg::LEN_W'(ffa_pkg::WANT_W'(e_len)
                                                             - want_reg);
                            state_next     = ST_SPLIT;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (at_end)
                    begin
                        status_next = ffa_pkg::STATUS_NO_SPACE;
                        addr_next   = '0;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        s_next        = blk_end[ffa_pkg::UNIT_W-1:0];
                        mem_req.raddr = blk_end[ffa_pkg::UNIT_W-1:0];
                    end
                end
                else
                begin
                    if (s_addr == target_reg)
                    begin
                        addr_next = '0;
                        if (!e_used)
                        begin
                            status_next = ffa_pkg::STATUS_FREE_FAIL;
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else if (at_end)
                        begin
                            // last block: merge with a free predecessor only
                            mem_req.we = 1'b1;
                            if (prev_free_reg)
                            begin
                                mem_req.waddr = prev_s_reg;
                                mem_req.wdata = {1'b0, ffa_pkg::LEN_W'(prev_len_reg
                                                                       + free_len)};
                            end
                            else
                            begin
                                mem_req.waddr = free_s;
                                mem_req.wdata = {1'b0, free_len};
                            end
                            status_next = ffa_pkg::STATUS_OK;
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            cur_s_next    = s_reg;
                            cur_len_next  = e_len;
                            mem_req.raddr = blk_end[ffa_pkg::UNIT_W-1:0];
                            state_next    = ST_FNEXT;
                        end
                    end
                    else if (at_end)
                    begin
                        status_next = ffa_pkg::STATUS_FREE_FAIL;
                        addr_next   = '0;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        prev_s_next    = s_reg;
                        prev_len_next  = e_len;
                        prev_free_next = !e_used;
                        s_next         = blk_end[ffa_pkg::UNIT_W-1:0];
                        mem_req.raddr  = blk_end[ffa_pkg::UNIT_W-1:0];
                    end
                end
            end
            ST_SPLIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = split_s_reg;
                mem_req.wdata = {1'b0, split_len_reg};
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_FNEXT:
            begin
                mem_req.we = 1'b1;
                if (prev_free_reg)
                begin
                    mem_req.waddr = prev_s_reg;
                    mem_req.wdata = {1'b0, ffa_pkg::LEN_W'(prev_len_reg + free_len)};
                end
                else
                begin
                    mem_req.waddr = free_s;
                    mem_req.wdata = {1'b0, free_len};
                end
                status_next = ffa_pkg::STATUS_OK;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        if (reinit)
        begin
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        op_reg        <= op_next;
        want_reg      <= want_next;
        target_reg    <= target_next;
        prev_s_reg    <= prev_s_next;
        prev_len_reg  <= prev_len_next;
        prev_free_reg <= prev_free_next;
        cur_s_reg     <= cur_s_next;
        cur_len_reg   <= cur_len_next;
        split_s_reg   <= split_s_next;
        split_len_reg <= split_len_next;
        status_reg    <= status_next;
        addr_reg      <= addr_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign addr   = addr_reg;

endmodule

/* design/first_fit_heap_allocator.sv */
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap manager with split on allocate and merge on free.
// ---------------------------------------------------------------------------
// Usage: pulse start with op/size_bytes/free_addr while busy is low; the item
// is taken at that edge. One result comes back on status/addr, qualified by a
// one-cycle done pulse, which the receiver must take as it comes. The walker
// visits one block per cycle, bounded by the single read port of the block
// table, and a split allocate adds a remainder write, a free that does not hit
// the last block a follower read. busy drops in the same cycle done is shown.
// After reset or a heap_units write the walker rebuilds the single free block
// in its init state, during which busy is high.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ffa_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic [ffa_pkg::SIZE_W-1:0]      size_bytes,
    input  logic [ffa_pkg::ADDR_W-1:0]      free_addr,
    output logic                            done,
    output logic [ffa_pkg::STATUS_W-1:0]    status,
    output logic [ffa_pkg::ADDR_W-1:0]      addr
);

`include "assert_macros.svh"

    // heap size register; a write re-initializes the heap
    logic [ffa_pkg::CFG_W-1:0]   heap_units_reg;
    logic [ffa_pkg::LEN_W-1:0]   n_units;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_units_reg <= ffa_pkg::HEAP_UNITS_RESET;
        end
        else if (cfg_we)
        begin
            heap_units_reg <= cfg_wdata;
        end
    end

    // zero acts as one unit, oversize clamps to the table depth
    always_comb
    begin
        if (heap_units_reg == '0)
        begin
            n_units = ffa_pkg::LEN_W'(1);
        end
        else if (ffa_pkg::LEN_W'(heap_units_reg) > ffa_pkg::LEN_W'(ffa_pkg::MAX_UNITS))
        begin
            n_units = ffa_pkg::LEN_W'(ffa_pkg::MAX_UNITS);
        end
        else
        begin
            n_units = ffa_pkg::LEN_W'(heap_units_reg);
        end
    end

    // Block table: one entry per start unit, {used, length}. Only entries at
    // block starts carry meaning, so rebuilding the heap only rewrites entry 0.
    ffa_pkg::mem_req_t             mem_req;
    logic [ffa_pkg::ENTRY_W-1:0]   mem_rdata;

    ffa_ram #(
        .WIDTH (ffa_pkg::ENTRY_W),
        .DEPTH (ffa_pkg::MAX_UNITS)
    ) u_table (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // Walker: reads the next block start each cycle, writes back at most one
    // entry per cycle. Reads and writes never target the same cycle's data,
    // since every write ends the walk for the current item.
    ffa_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .reinit     (cfg_we),
        .n_units    (n_units),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .size_bytes (size_bytes),
        .free_addr  (free_addr),
        .done       (done),
        .status     (status),
        .addr       (addr),
        .mem_req    (mem_req),
        .rdata      (mem_rdata)
    );

    // ---- assertions ----
    logic status_legal;
    logic fail_result;

    assign status_legal = (status == ffa_pkg::STATUS_OK)
                        || (status == ffa_pkg::STATUS_NO_SPACE)
                        || (status == ffa_pkg::STATUS_FREE_FAIL);
    assign fail_result  = done && (status != ffa_pkg::STATUS_OK);

    `ASSERT_IMPLY(a_status_legal, done, status_legal, "illegal status code")
    `ASSERT_IMPLY(a_fail_addr_zero, fail_result, addr == '0, "addr nonzero on failure")
    `ASSERT_NEXT(a_accept_busy, start && !busy && !cfg_we, busy, "accepted item did not raise busy")
    `ASSERT_NEXT(a_done_idle, done, !done, "result strobe longer than one cycle")

endmodule

/* verif/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for first_fit_heap_allocator. It keeps a shadow copy of
// the block table, predicts status/addr for every accepted item, and compares
// each done pulse with the oldest expectation in order. It runs a short table
// of directed items, then random alloc/free traffic over several heap sizes
// and sender idle rates.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    // ------------------------------------------------------------------
    // DUT ports: every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata  = '0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic                  op         = OP_ALLOC;
    logic [SIZE_W-1:0]     size_bytes = '0;
    logic [ADDR_W-1:0]     free_addr  = '0;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [ADDR_W-1:0]     addr;

    first_fit_heap_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .size_bytes (size_bytes),
        .free_addr  (free_addr),
        .done       (done),
        .status     (status),
        .addr       (addr)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Expected results, oldest first
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } heap_result_t;

    heap_result_t pending_results[$];
    int           mismatches = 0;
    int           idle_pct   = 0;

    // ------------------------------------------------------------------
    // Shadow heap: one entry per start unit, length and taken flag.
    // Only entries at block starts carry meaning, same as the DUT table.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] heap_cfg;
    int               unit_len   [MAX_UNITS];
    bit               unit_taken [MAX_UNITS];

    // heap_units of 0 behaves as 1, anything above the table depth as the depth
    function automatic int heap_span();
        if (heap_cfg == 0)
            return 1;
        if (int'(heap_cfg) > MAX_UNITS)
            return MAX_UNITS;
        return int'(heap_cfg);
    endfunction

    function automatic void rebuild_heap();
        foreach (unit_len[i])
        begin
            unit_len[i]   = 0;
            unit_taken[i] = 1'b0;
        end
        unit_len[0] = heap_span();
    endfunction

    // a zero length entry is stepped over one unit at a time
    function automatic int stride(int u);
        return (unit_len[u] != 0) ? unit_len[u] : 1;
    endfunction

    // fold every run of free blocks into its first block, stopping at heap end
    function automatic void merge_free_runs();
        int n;
        int u;
        int nx;
        n = heap_span();
        u = 0;
        while (u < n)
        begin
            if (!unit_taken[u])
            begin
                nx = u + stride(u);
                while (nx < n && !unit_taken[nx])
                begin
                    unit_len[u] += stride(nx);
                    nx = u + unit_len[u];
                end
            end
            u += stride(u);
        end
    endfunction

    // apply one request to the shadow heap and return what the DUT must answer
    function automatic heap_result_t predict_request(logic rop, logic [SIZE_W-1:0] rsize,
                                                     logic [ADDR_W-1:0] rfaddr);
        heap_result_t res;
        int n;
        int u;
        int want;
        n   = heap_span();
        u   = 0;
        res = '0;
        if (rop == OP_ALLOC)
        begin
            want = (int'(rsize) + UNIT_BYTES - 1) / UNIT_BYTES;
            if (want == 0)
                want = 1;
            res.status = STATUS_NO_SPACE;
            while (u < n)
            begin
                if (!unit_taken[u] && unit_len[u] >= want)
                begin
                    if (unit_len[u] > want)
                    begin
                        unit_len[u + want]   = unit_len[u] - want;
                        unit_taken[u + want] = 1'b0;
                    end
                    unit_len[u]   = want;
                    unit_taken[u] = 1'b1;
                    res.status    = STATUS_OK;
                    res.addr      = ADDR_W'(u * UNIT_BYTES);
                    break;
                end
                u += stride(u);
            end
        end
        else
        begin
            res.status = STATUS_FREE_FAIL;
            while (u < n)
            begin
                if (u * UNIT_BYTES == int'(rfaddr))
                begin
                    // freeing a block that is already free changes nothing
                    if (unit_taken[u])
                    begin
                        unit_taken[u] = 1'b0;
                        merge_free_runs();
                        res.status = STATUS_OK;
                    end
                    break;
                end
                u += stride(u);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random traffic: mostly small allocs and frees of live blocks so the
    // heap fragments, splits and merges; the rest is out-of-range noise.
    // The unused field of each item is random so its bits toggle too.
    // ------------------------------------------------------------------
    function automatic void pick_random_request(output logic rop,
                                                output logic [SIZE_W-1:0] rsize,
                                                output logic [ADDR_W-1:0] rfaddr);
        int live_starts[$];
        int roll;
        int u;
        roll   = $urandom_range(0, 99);
        rsize  = SIZE_W'($urandom_range(0, 1023));
        rfaddr = ADDR_W'($urandom_range(0, 511));
        u = 0;
        while (u < heap_span())
        begin
            if (unit_taken[u])
                live_starts.push_back(u);
            u += stride(u);
        end
        if (roll >= 45 && roll < 85 && live_starts.size() != 0)
        begin
            rop    = OP_FREE;
            rfaddr = ADDR_W'(live_starts[$urandom_range(0, live_starts.size() - 1)]
                             * UNIT_BYTES);
        end
        else if (roll >= 85 && roll < 93)
        begin
            rop = OP_ALLOC;     // any size, often too big
        end
        else if (roll >= 93)
        begin
            rop = OP_FREE;      // any offset: misaligned, inside a block, past the end
        end
        else
        begin
            rop = OP_ALLOC;
            if ($urandom_range(0, 3) == 0)
                rsize = SIZE_W'($urandom_range(0, heap_span() * UNIT_BYTES));
            else
                rsize = SIZE_W'($urandom_range(0, 32));
        end
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting; output is capped so a dead DUT stays readable
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, sampled pre-edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending, status", int'(status), -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", int'(status), int'(want.status));
                if (addr !== want.addr)
                    report_mismatch("addr", int'(addr), int'(want.addr));
            end
        end
    end

    // ------------------------------------------------------------------
    // Item driver. Called at a rising edge; start may still be high from the
    // previous item, so it is either lowered for an idle gap or reloaded
    // with the new item in this same step, never both. Each idle cycle is
    // drawn on its own at idle_pct percent.
    // ------------------------------------------------------------------
    task automatic issue_request(logic rop, logic [SIZE_W-1:0] rsize,
                                 logic [ADDR_W-1:0] rfaddr, bit has_answer,
                                 heap_result_t answer);
        heap_result_t predicted;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        op         <= rop;
        size_bytes <= rsize;
        free_addr  <= rfaddr;
        // taken at the first edge where busy is low
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = predict_request(rop, rsize, rfaddr);
        pending_results.push_back(has_answer ? answer : predicted);
    endtask

    // heap_units write: only once the block has drained and start is low
    task automatic write_heap_units(logic [CFG_W-1:0] units);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= units;
        @(posedge clk);
        cfg_we    <= 1'b0;
        heap_cfg = units;
        rebuild_heap();
    endtask

    // ------------------------------------------------------------------
    // Directed items, run on the reset heap of 40 units. Expected values are
    // filled in where they are obvious; other rows go to the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic                op;
        logic [SIZE_W-1:0]   size;
        logic [ADDR_W-1:0]   faddr;
        logic                has_answer;
        logic [STATUS_W-1:0] exp_status;
        logic [ADDR_W-1:0]   exp_addr;
    } request_row_t;

    localparam int NUM_ROWS = 22;

    request_row_t directed_rows [NUM_ROWS] = '{
        '{OP_ALLOC, 10'd0,    9'h1FF, 1'b1, STATUS_OK,        9'd0},   // zero bytes = one unit
        '{OP_ALLOC, 10'd1,    9'd0,   1'b1, STATUS_OK,        9'd8},
        '{OP_ALLOC, 10'd8,    9'd0,   1'b1, STATUS_OK,        9'd16},
        '{OP_ALLOC, 10'd9,    9'd0,   1'b1, STATUS_OK,        9'd24},  // rounds up to two units
        '{OP_ALLOC, 10'd512,  9'd0,   1'b1, STATUS_NO_SPACE,  9'd0},
        '{OP_ALLOC, 10'h3FF,  9'h1FF, 1'b1, STATUS_NO_SPACE,  9'd0},
        '{OP_FREE,  10'h3FF,  9'd4,   1'b1, STATUS_FREE_FAIL, 9'd0},   // misaligned
        '{OP_FREE,  10'd0,    9'd8,   1'b1, STATUS_OK,        9'd0},
        '{OP_FREE,  10'd0,    9'd8,   1'b1, STATUS_FREE_FAIL, 9'd0},   // already free
        '{OP_ALLOC, 10'd8,    9'd0,   1'b1, STATUS_OK,        9'd8},   // first fit reuses hole
        '{OP_FREE,  10'd0,    9'h1FF, 1'b1, STATUS_FREE_FAIL, 9'd0},
        '{OP_FREE,  10'd0,    9'd320, 1'b1, STATUS_FREE_FAIL, 9'd0},   // past heap end
        '{OP_FREE,  10'd0,    9'd16,  1'b0, STATUS_OK,        9'd0},
        '{OP_FREE,  10'd0,    9'd0,   1'b0, STATUS_OK,        9'd0},
        '{OP_FREE,  10'd0,    9'd8,   1'b0, STATUS_OK,        9'd0},   // merges both sides
        '{OP_ALLOC, 10'd280,  9'd0,   1'b0, STATUS_OK,        9'd0},   // skips a small hole
        '{OP_FREE,  10'd0,    9'd40,  1'b0, STATUS_OK,        9'd0},
        '{OP_FREE,  10'd0,    9'd24,  1'b0, STATUS_OK,        9'd0},   // heap whole again
        '{OP_ALLOC, 10'd320,  9'd0,   1'b0, STATUS_OK,        9'd0},   // exactly the heap
        '{OP_ALLOC, 10'd0,    9'd0,   1'b1, STATUS_NO_SPACE,  9'd0},
        '{OP_FREE,  10'd0,    9'd0,   1'b0, STATUS_OK,        9'd0},
        '{OP_ALLOC, 10'd321,  9'd0,   1'b1, STATUS_NO_SPACE,  9'd0}    // one unit too many
    };

    // heap sizes per random segment: extremes, out-of-range codes, random picks
    int segment_heap [9] = '{64, 1, 127, 0, 40, 23, -1, -1, 64};

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic              rop;
        logic [SIZE_W-1:0] rsize;
        logic [ADDR_W-1:0] rfaddr;
        logic [CFG_W-1:0]  units;
        int                drain_cycles;

        heap_cfg = HEAP_UNITS_RESET;
        rebuild_heap();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, back to back, on the reset heap
        foreach (directed_rows[i])
            issue_request(directed_rows[i].op, directed_rows[i].size,
                          directed_rows[i].faddr, directed_rows[i].has_answer,
                          '{directed_rows[i].exp_status, directed_rows[i].exp_addr});

        // random part: sender idles 22%, then 46%, then never
        for (int seg = 0; seg < 9; seg++)
        begin
            idle_pct = (seg < 3) ? 22 : (seg < 6) ? 46 : 0;
            units = (segment_heap[seg] < 0) ? CFG_W'($urandom_range(0, 127))
                                            : CFG_W'(segment_heap[seg]);
            write_heap_units(units);
            for (int k = 0; k < 87; k++)
            begin
                pick_random_request(rop, rsize, rfaddr);
                issue_request(rop, rsize, rfaddr, 1'b0, '0);
            end
        end

        // drain: every item answers once
        start <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 5000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (80) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never returned", 0, pending_results.size());

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog: fails a run that never reaches the end of the main sequence
    initial
    begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
